// ===== rtl/bha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bha_pkg
// Types and constants shared by the heap allocator and its cell rows.
// ----------------------------------------------------------------------------
package bha_pkg;

  localparam int HEAP_SIZE = 1024;

  localparam logic [1:0] OP_FIRST = 2'd0;
  localparam logic [1:0] OP_BEST  = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NOMEM = 3'd1;
  localparam logic [2:0] ST_NOTAG = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_ZERO  = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [10:0] request_size;
    logic [15:0] tag;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  base_addr;
    logic [10:0] block_size;
  } res_t;

  typedef struct packed {
    logic [9:0]  start;
    logic [10:0] size;
  } hole_t;

  typedef struct packed {
    logic [9:0]  start;
    logic [10:0] size;
    logic [15:0] tag;
  } used_t;

  // Row operations: every cell acts on its own entry and its neighbors.
  typedef enum logic [2:0] {
    C_HOLD,
    C_ROT,
    C_INS,
    C_DEL,
    C_WR
  } chain_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HSCAN,
    S_HEDIT,
    S_USCAN,
    S_UINS,
    S_FSCAN,
    S_FDEL,
    S_FHSCAN,
    S_FHEDIT,
    S_FHDEL
  } state_t;

endpackage

// ===== rtl/bha_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bha_cell
// One table entry with a valid bit, loaded from itself, a neighbor or a new value.
// ----------------------------------------------------------------------------
module bha_cell import bha_pkg::*; #(
  parameter int         W     = 21,
  parameter int         IW    = 7,
  parameter int         IDX   = 0,
  parameter bit         LAST  = 1'b0,
  parameter bit         RST_V = 1'b0,
  parameter logic [W-1:0] RST_D = '0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  chain_op_t     op,
  input  logic [IW-1:0] idx,
  input  logic [W-1:0]  din,
  input  logic          left_v,
  input  logic [W-1:0]  left_d,
  input  logic          right_v,
  input  logic [W-1:0]  right_d,
  output logic          v,
  output logic [W-1:0]  d
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic          v_r, v_nxt;
  logic [W-1:0]  d_r, d_nxt;

  always_comb begin
    v_nxt = v_r;
    d_nxt = d_r;
    unique case (op)
      C_HOLD: begin
      end
      C_ROT: begin
        v_nxt = right_v;
        d_nxt = right_d;
      end
      C_INS: begin
        if (MY_IDX > idx) begin
          v_nxt = left_v;
          d_nxt = left_d;
        end else if (MY_IDX == idx) begin
          v_nxt = 1'b1;
          d_nxt = din;
        end
      end
      C_DEL: begin
        if (MY_IDX >= idx) begin
          // The end of the row takes an empty entry instead of wrapping around.
          v_nxt = LAST ? 1'b0 : right_v;
          d_nxt = right_d;
        end
      end
      C_WR: begin
        if (MY_IDX == idx) d_nxt = din;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= RST_V;
      d_r <= RST_D;
    end else begin
      v_r <= v_nxt;
      d_r <= d_nxt;
    end
  end

  assign v = v_r;
  assign d = d_r;

endmodule

// ===== rtl/bha_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bha_chain
// A row of table cells that rotates, inserts, deletes or writes one entry.
// ----------------------------------------------------------------------------
module bha_chain import bha_pkg::*; #(
  parameter int           DEPTH      = 64,
  parameter int           W          = 21,
  parameter bit           RST_HEAD_V = 1'b0,
  parameter logic [W-1:0] RST_HEAD_D = '0,
  localparam int          IW         = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  chain_op_t     op,
  input  logic [IW-1:0] idx,
  input  logic [W-1:0]  din,
  output logic          head_v,
  output logic [W-1:0]  head_d,
  output logic          last_v
);

  logic          cv [DEPTH];
  logic [W-1:0]  cd [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          lv, rv;
    logic [W-1:0]  ld, rd;
    if (i == 0) begin : g_first
      assign lv = 1'b0;
      assign ld = '0;
    end else begin : g_mid
      assign lv = cv[i-1];
      assign ld = cd[i-1];
    end
    if (i == DEPTH - 1) begin : g_wrap
      assign rv = cv[0];
      assign rd = cd[0];
    end else begin : g_next
      assign rv = cv[i+1];
      assign rd = cd[i+1];
    end
    bha_cell #(
      .W    (W),
      .IW   (IW),
      .IDX  (i),
      .LAST (i == DEPTH - 1),
      .RST_V((i == 0) ? RST_HEAD_V : 1'b0),
      .RST_D((i == 0) ? RST_HEAD_D : '0)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .op     (op),
      .idx    (idx),
      .din    (din),
      .left_v (lv),
      .left_d (ld),
      .right_v(rv),
      .right_d(rd),
      .v      (cv[i]),
      .d      (cd[i])
    );
  end

  assign head_v = cv[0];
  assign head_d = cd[0];
  assign last_v = cv[DEPTH-1];

endmodule

// ===== rtl/block_heap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_heap_allocator
// First-fit / best-fit heap allocator over two rows of table cells.
// ----------------------------------------------------------------------------
// Allocation: hole scan, hole edit, used scan, insert; with no fitting hole it answers
// after the hole scan. Free: used scan, block delete, hole scan, hole edit, plus a
// hole delete when two holes join; an unknown tag answers after the used scan. Zero size,
// table full and the unused opcode answer from idle. Each scan rotates a whole row once.
// One item at a time: busy is high while an item is at work; results cannot be held off.
// Synchronous reset clears the used table and leaves one hole spanning the heap.
module block_heap_allocator import bha_pkg::*; #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_data,
  output logic out_valid,
  output res_t out_data
);

  localparam int HD  = MAX_BLOCKS + 1;
  localparam int UIW = $clog2(MAX_BLOCKS);
  localparam int HIW = $clog2(HD);
  localparam int CW  = $clog2(HD + 1);
  localparam int HW  = $bits(hole_t);
  localparam int UW  = $bits(used_t);
  localparam hole_t HOLE_RST = '{start: 10'd0, size: 11'(HEAP_SIZE)};

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   p_r, p_nxt;
  logic [HIW-1:0]  pick_r, pick_nxt;
  logic            found_r, found_nxt;
  logic            done_r, done_nxt;
  logic [10:0]     least_r, least_nxt;
  logic [9:0]      s_r, s_nxt;
  logic [10:0]     z_r, z_nxt;
  logic [10:0]     req_r, req_nxt;
  logic [15:0]     tag_r, tag_nxt;
  logic            best_r, best_nxt;
  hole_t           prev_r, prev_nxt;
  hole_t           nxt_r, nxt_nxt;
  logic            nfound_r, nfound_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            out_r, out_nxt;

  chain_op_t       h_op, u_op;
  logic [HIW-1:0]  h_idx;
  logic [UIW-1:0]  u_idx;
  hole_t           h_din, h_head;
  used_t           u_din, u_head;
  logic            h_hv, u_hv, h_lv, u_lv;
  logic [HW-1:0]   h_hd;
  logic [UW-1:0]   u_hd;
  logic            scan_end_h, scan_end_u, left_j, right_j;

  bha_chain #(
    .DEPTH     (HD),
    .W         (HW),
    .RST_HEAD_V(1'b1),
    .RST_HEAD_D(HOLE_RST)
  ) u_holes (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (h_op),
    .idx   (h_idx),
    .din   (h_din),
    .head_v(h_hv),
    .head_d(h_hd),
    .last_v(h_lv)
  );

  bha_chain #(
    .DEPTH     (MAX_BLOCKS),
    .W         (UW),
    .RST_HEAD_V(1'b0),
    .RST_HEAD_D('0)
  ) u_used (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (u_op),
    .idx   (u_idx),
    .din   (u_din),
    .head_v(u_hv),
    .head_d(u_hd),
    .last_v(u_lv)
  );

  assign h_head = hole_t'(h_hd);
  assign u_head = used_t'(u_hd);
  assign scan_end_h = (cnt_r == CW'(HD - 1));
  assign scan_end_u = (cnt_r == CW'(MAX_BLOCKS - 1));
  // The last hole never fills: there is at most one more hole than blocks.
  assign left_j  = (p_r != '0) &&
                   (({2'b0, prev_r.start} + {1'b0, prev_r.size}) == {2'b0, s_r});
  assign right_j = nfound_r && (({2'b0, s_r} + {1'b0, z_r}) == {2'b0, nxt_r.start});

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    p_nxt         = p_r;
    pick_nxt      = pick_r;
    found_nxt     = found_r;
    done_nxt      = done_r;
    least_nxt     = least_r;
    s_nxt         = s_r;
    z_nxt         = z_r;
    req_nxt       = req_r;
    tag_nxt       = tag_r;
    best_nxt      = best_r;
    prev_nxt      = prev_r;
    nxt_nxt       = nxt_r;
    nfound_nxt    = nfound_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    h_op          = C_HOLD;
    u_op          = C_HOLD;
    h_idx         = '0;
    u_idx         = '0;
    h_din         = '0;
    u_din         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_data.request_size;
          tag_nxt    = in_data.tag;
          best_nxt   = (in_data.opcode == OP_BEST);
          cnt_nxt    = '0;
          p_nxt      = '0;
          found_nxt  = 1'b0;
          done_nxt   = 1'b0;
          nfound_nxt = 1'b0;
          least_nxt  = 11'(HEAP_SIZE);
          if (in_data.opcode == OP_FIRST || in_data.opcode == OP_BEST) begin
            if (in_data.request_size == '0) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: ST_ZERO, base_addr: '0, block_size: '0};
            end else if (u_lv) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: ST_FULL, base_addr: '0, block_size: '0};
            end else begin
              state_nxt = S_HSCAN;
            end
          end else if (in_data.opcode == OP_FREE) begin
            state_nxt = S_FSCAN;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ST_OK, base_addr: '0, block_size: '0};
          end
        end
      end

      S_HSCAN: begin
        h_op = C_ROT;
        if (h_hv && !done_r) begin
          if (!best_r) begin
            if (h_head.size >= req_r) begin
              found_nxt = 1'b1;
              done_nxt  = 1'b1;
              pick_nxt  = cnt_r[HIW-1:0];
              s_nxt     = h_head.start;
              z_nxt     = h_head.size;
            end
          end else if (h_head.size == req_r) begin
            found_nxt = 1'b1;
            done_nxt  = 1'b1;
            pick_nxt  = cnt_r[HIW-1:0];
            s_nxt     = h_head.start;
            z_nxt     = h_head.size;
          end else if (h_head.size > req_r && h_head.size <= least_r) begin
            // Equal sizes go to the later hole.
            found_nxt = 1'b1;
            least_nxt = h_head.size;
            pick_nxt  = cnt_r[HIW-1:0];
            s_nxt     = h_head.start;
            z_nxt     = h_head.size;
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (scan_end_h) begin
          cnt_nxt   = '0;
          state_nxt = S_HEDIT;
        end
      end

      S_HEDIT: begin
        if (!found_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_NOMEM, base_addr: '0, block_size: '0};
          state_nxt     = S_IDLE;
        end else begin
          h_idx = pick_r;
          if (z_r == req_r) begin
            h_op = C_DEL;
          end else begin
            h_op  = C_WR;
            h_din = '{start: 10'({1'b0, s_r} + req_r), size: z_r - req_r};
          end
          state_nxt = S_USCAN;
        end
      end

      S_USCAN: begin
        u_op = C_ROT;
        if (u_hv && u_head.start <= s_r) p_nxt = p_r + 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (scan_end_u) begin
          cnt_nxt   = '0;
          state_nxt = S_UINS;
        end
      end

      S_UINS: begin
        u_op          = C_INS;
        u_idx         = p_r[UIW-1:0];
        u_din         = '{start: s_r, size: req_r, tag: tag_r};
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: ST_OK, base_addr: s_r, block_size: req_r};
        state_nxt     = S_IDLE;
      end

      S_FSCAN: begin
        u_op = C_ROT;
        if (u_hv && !found_r && u_head.tag == tag_r) begin
          found_nxt = 1'b1;
          pick_nxt  = HIW'(cnt_r);
          s_nxt     = u_head.start;
          z_nxt     = u_head.size;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (scan_end_u) begin
          cnt_nxt   = '0;
          state_nxt = S_FDEL;
        end
      end

      S_FDEL: begin
        if (!found_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_NOTAG, base_addr: '0, block_size: '0};
          state_nxt     = S_IDLE;
        end else begin
          u_op      = C_DEL;
          u_idx     = pick_r[UIW-1:0];
          state_nxt = S_FHSCAN;
        end
      end

      S_FHSCAN: begin
        h_op = C_ROT;
        if (h_hv) begin
          if (h_head.start <= s_r) begin
            p_nxt    = p_r + 1'b1;
            prev_nxt = h_head;
          end else if (!nfound_r) begin
            nfound_nxt = 1'b1;
            nxt_nxt    = h_head;
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (scan_end_h) begin
          cnt_nxt   = '0;
          state_nxt = S_FHEDIT;
        end
      end

      S_FHEDIT: begin
        out_nxt   = '{status: ST_OK, base_addr: s_r, block_size: z_r};
        state_nxt = S_IDLE;
        if (left_j && right_j) begin
          h_op      = C_WR;
          h_idx     = HIW'(p_r - 1'b1);
          h_din     = '{start: prev_r.start, size: prev_r.size + z_r + nxt_r.size};
          state_nxt = S_FHDEL;
        end else if (left_j) begin
          h_op          = C_WR;
          h_idx         = HIW'(p_r - 1'b1);
          h_din         = '{start: prev_r.start, size: prev_r.size + z_r};
          out_valid_nxt = 1'b1;
        end else if (right_j) begin
          h_op          = C_WR;
          h_idx         = p_r[HIW-1:0];
          h_din         = '{start: s_r, size: nxt_r.size + z_r};
          out_valid_nxt = 1'b1;
        end else begin
          if (!h_lv) begin
            h_op  = C_INS;
            h_idx = p_r[HIW-1:0];
            h_din = '{start: s_r, size: z_r};
          end
          out_valid_nxt = 1'b1;
        end
      end

      S_FHDEL: begin
        h_op          = C_DEL;
        h_idx         = p_r[HIW-1:0];
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: ST_OK, base_addr: s_r, block_size: z_r};
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r      <= p_nxt;
    pick_r   <= pick_nxt;
    found_r  <= found_nxt;
    done_r   <= done_nxt;
    least_r  <= least_nxt;
    s_r      <= s_nxt;
    z_r      <= z_nxt;
    req_r    <= req_nxt;
    tag_r    <= tag_nxt;
    best_r   <= best_nxt;
    prev_r   <= prev_nxt;
    nxt_r    <= nxt_nxt;
    nfound_r <= nfound_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== verif/block_heap_allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_heap_allocator_checker
// Watches the request and result beats of the heap allocator, keeps its own
// copy of the allocated and free tables, and compares each result in order.
// ----------------------------------------------------------------------------
module block_heap_allocator_checker import bha_pkg::*; #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  req_t in_data,
  input  logic out_valid,
  input  res_t out_data,
  output int   fail_count,
  output int   pending
);

  localparam int HOLE_DEPTH = MAX_BLOCKS + 1;

  used_t blk_tab[MAX_BLOCKS];
  int    blk_cnt;
  hole_t gap_tab[HOLE_DEPTH];
  int    gap_cnt;
  res_t  result_q[$];

  function automatic void heap_clear();
    blk_cnt = 0;
    gap_cnt = 1;
    gap_tab[0].start = '0;
    gap_tab[0].size = 11'(HEAP_SIZE);
  endfunction

  function automatic res_t heap_apply(req_t r);
    res_t  o;
    int    pick, least, p, i;
    bit    found, lft, rgt;
    hole_t h;
    used_t u;
    o = '0;
    found = 0;
    pick = 0;
    if (r.opcode == OP_FIRST || r.opcode == OP_BEST) begin
      if (r.request_size == 0) begin
        o.status = ST_ZERO;
      end else if (blk_cnt >= MAX_BLOCKS) begin
        o.status = ST_FULL;
      end else begin
        least = HEAP_SIZE;
        for (i = 0; i < gap_cnt; i++) begin
          if (r.opcode == OP_FIRST) begin
            if (gap_tab[i].size >= r.request_size) begin
              pick = i; found = 1; break;
            end
          end else begin
            if (gap_tab[i].size == r.request_size) begin
              pick = i; found = 1; break;
            end
            if (gap_tab[i].size > r.request_size && gap_tab[i].size <= least) begin
              least = gap_tab[i].size; pick = i; found = 1;
            end
          end
        end
        if (!found) begin
          o.status = ST_NOMEM;
        end else begin
          o.status = ST_OK;
          o.base_addr = gap_tab[pick].start;
          o.block_size = r.request_size;
          if (gap_tab[pick].size == r.request_size) begin
            for (i = pick; i + 1 < gap_cnt; i++) gap_tab[i] = gap_tab[i + 1];
            gap_cnt--;
          end else begin
            gap_tab[pick].start += r.request_size[9:0];
            gap_tab[pick].size -= r.request_size;
          end
          p = 0;
          while (p < blk_cnt && blk_tab[p].start <= o.base_addr) p++;
          for (i = blk_cnt; i > p; i--) blk_tab[i] = blk_tab[i - 1];
          blk_tab[p] = '{o.base_addr, r.request_size, r.tag};
          blk_cnt++;
        end
      end
    end else if (r.opcode == OP_FREE) begin
      for (i = 0; i < blk_cnt; i++) if (blk_tab[i].tag == r.tag) break;
      if (i >= blk_cnt) begin
        o.status = ST_NOTAG;
      end else begin
        u = blk_tab[i];
        for (; i + 1 < blk_cnt; i++) blk_tab[i] = blk_tab[i + 1];
        blk_cnt--;
        o.status = ST_OK;
        o.base_addr = u.start;
        o.block_size = u.size;
        p = 0;
        while (p < gap_cnt && gap_tab[p].start <= u.start) p++;
        lft = p > 0 && (int'(gap_tab[p - 1].start) + int'(gap_tab[p - 1].size)
                        == int'(u.start));
        rgt = p < gap_cnt && (int'(u.start) + int'(u.size) == int'(gap_tab[p].start));
        if (lft && rgt) begin
          gap_tab[p - 1].size += u.size + gap_tab[p].size;
          for (i = p; i + 1 < gap_cnt; i++) gap_tab[i] = gap_tab[i + 1];
          gap_cnt--;
        end else if (lft) begin
          gap_tab[p - 1].size += u.size;
        end else if (rgt) begin
          gap_tab[p].start = u.start;
          gap_tab[p].size += u.size;
        end else if (gap_cnt < HOLE_DEPTH) begin
          for (i = gap_cnt; i > p; i--) gap_tab[i] = gap_tab[i - 1];
          h.start = u.start;
          h.size = u.size;
          gap_tab[p] = h;
          gap_cnt++;
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      heap_clear();
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat, actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = result_q.pop_front();
          if (e !== out_data) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) result_q.push_back(heap_apply(in_data));
    end
    pending <= result_q.size();
  end

endmodule

// ===== verif/block_heap_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_heap_allocator_tb
// Drives directed and random allocate and free requests into the heap
// allocator under varying idle patterns; the checker judges every result.
// ----------------------------------------------------------------------------
module block_heap_allocator_tb import bha_pkg::*;;

  localparam int MAX_BLOCKS = 64;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_data;
  logic out_valid;
  res_t out_data;
  int   fail_count;
  int   pending;
  int   idle_pct;
  int   quiet_cycles;
  logic [15:0] live_tags[$];

  block_heap_allocator #(.MAX_BLOCKS(MAX_BLOCKS)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  block_heap_allocator_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Holds the request until the block takes the beat, idling before it.
  // start stays high after the beat until the next idle cycle or wait.
  task automatic send_req(logic [1:0] op, logic [10:0] sz, logic [15:0] tg);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{op, sz, tg};
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op != OP_FREE && tg != 0) live_tags.push_back(tg);
  endtask

  // Drops start and waits until every expected result has come.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_req();
    int          r, k;
    logic [15:0] tg;
    logic [10:0] sz;
    r = $urandom_range(99);
    if (r < 3) begin
      send_req(OP_NOP, 11'($urandom), 16'($urandom));
    end else if (r < 40 && live_tags.size() > 0) begin
      k = $urandom_range(live_tags.size() - 1);
      tg = live_tags[k];
      live_tags.delete(k);
      send_req(OP_FREE, 11'($urandom), tg);
    end else if (r < 44) begin
      send_req(OP_FREE, 11'($urandom), 16'($urandom));
    end else begin
      case ($urandom_range(9))
        0: sz = 11'($urandom);
        1: sz = 11'($urandom_range(100, 600));
        default: sz = 11'($urandom_range(1, 40));
      endcase
      tg = ($urandom_range(4) == 0) ? 16'($urandom_range(1, 8)) : 16'($urandom);
      send_req($urandom_range(1) ? OP_BEST : OP_FIRST, sz, tg);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    idle_pct = 0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, every opcode, error cases, merges, duplicate tags.
    send_req(OP_FIRST, 11'd0, 16'hFFFF);
    send_req(OP_BEST, 11'd1025, 16'h0000);
    send_req(OP_FIRST, 11'h7FF, 16'h1234);
    send_req(OP_FREE, 11'd5, 16'hABCD);
    send_req(OP_NOP, 11'h7FF, 16'hFFFF);
    send_req(OP_FIRST, 11'd1024, 16'hFFFF);
    send_req(OP_BEST, 11'd1, 16'h0001);
    send_req(OP_FREE, 11'd0, 16'hFFFF);
    send_req(OP_FIRST, 11'd10, 16'd7);
    send_req(OP_FIRST, 11'd20, 16'd7);
    send_req(OP_FIRST, 11'd30, 16'd8);
    send_req(OP_FIRST, 11'd10, 16'd9);
    send_req(OP_FREE, 11'd0, 16'd7);
    send_req(OP_FREE, 11'd0, 16'd8);
    send_req(OP_BEST, 11'd30, 16'd10);
    send_req(OP_FREE, 11'd0, 16'd7);
    send_req(OP_BEST, 11'd5, 16'd11);
    send_req(OP_FREE, 11'd0, 16'd10);
    send_req(OP_FREE, 11'd0, 16'd9);
    send_req(OP_FREE, 11'd0, 16'd11);
    // Fill the used table to its limit, then overflow it and free the blocks added here.
    live_tags.delete();
    for (i = 0; i < MAX_BLOCKS + 2; i++) send_req(OP_FIRST, 11'd1, 16'(100 + i));
    for (i = 0; i < MAX_BLOCKS; i += 2) send_req(OP_FREE, 11'd0, 16'(100 + i));
    for (i = 1; i < MAX_BLOCKS; i += 2) send_req(OP_FREE, 11'd0, 16'(100 + i));
    live_tags.delete();
    drain();
    for (i = 0; i < 600; i++) begin
      idle_pct = (i < 200) ? 14 : (i < 400) ? 82 : 0;
      if (i == 300) drain();
      random_req();
    end
    drain();
    repeat (2 * MAX_BLOCKS + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bha_pkg.sv
rtl/bha_cell.sv
rtl/bha_chain.sv
rtl/block_heap_allocator.sv
verif/block_heap_allocator_checker.sv
verif/block_heap_allocator_tb.sv
